>>> rtl/lms7_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lms7_pkg
// Shared types, constants and the segment decoder for the scan driver.
// ============================================================================
package lms7_pkg;

  // Row store geometry and output widths
  localparam int unsigned NumRowsDefault = 5;
  localparam int unsigned SegW           = 8;
  localparam int unsigned DriveW         = 5;
  localparam int unsigned SelW           = 3;

  localparam logic [SegW-1:0] DotMask   = 8'h01;
  localparam logic [SegW-1:0] ColReset  = 8'h01;
  localparam logic [SegW-1:0] SegBlank  = 8'h00;

  // Operation selector
  typedef enum logic [2:0] {
    FUNC_TICK    = 3'd0,
    FUNC_DIGIT   = 3'd1,
    FUNC_DOT_ON  = 3'd2,
    FUNC_DOT_OFF = 3'd3,
    FUNC_CLEAR   = 3'd4,
    FUNC_DEC2    = 3'd5
  } func_e;

  typedef struct packed {
    logic [2:0] func;
    logic [2:0] row_sel;
    logic [2:0] second_row;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [DriveW-1:0] row_drive;
    logic [SegW-1:0]   column_drive;
  } out_item_t;

  // Seven-segment pattern for hex digits, dot and minus; blank past the end
  function automatic logic [SegW-1:0] seg_lookup(input logic [7:0] idx);
    logic [SegW-1:0] pat;
    case (idx)
      8'd0:    pat = 8'hFC;
      8'd1:    pat = 8'h60;
      8'd2:    pat = 8'hDA;
      8'd3:    pat = 8'hF2;
      8'd4:    pat = 8'h66;
      8'd5:    pat = 8'hB6;
      8'd6:    pat = 8'hBE;
      8'd7:    pat = 8'hE0;
      8'd8:    pat = 8'hFE;
      8'd9:    pat = 8'hF6;
      8'd10:   pat = 8'hEE;
      8'd11:   pat = 8'h3E;
      8'd12:   pat = 8'h9C;
      8'd13:   pat = 8'h7A;
      8'd14:   pat = 8'h9E;
      8'd15:   pat = 8'h8E;
      8'd16:   pat = 8'h01;
      8'd17:   pat = 8'h02;
      default: pat = SegBlank;
    endcase
    return pat;
  endfunction

endpackage

>>> rtl/lms7_core.sv
`timescale 1ns / 1ps
// ============================================================================
// lms7_core
// Segment row store and column pointer; applies one operation per transfer
// and forms the row/column drive for a refresh tick.
// ============================================================================
module lms7_core import lms7_pkg::*; #(
  parameter int unsigned NUM_ROWS = NumRowsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      exec_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  logic [SegW-1:0] rows_q [NUM_ROWS];
  logic [SegW-1:0] rows_d [NUM_ROWS];
  logic [SegW-1:0] col_q, col_d;

  logic [7:0]  prod;
  logic [16:0] prod_full;
  logic [7:0]  tens;
  logic [7:0]  units;
  logic [SegW-1:0] digit_pat, tens_pat, units_pat;
  func_e       func;

  assign func = func_e'(item_i.func);

  // Split value into decimal digits: tens = value * 205 >> 11
  assign prod_full = {9'd0, item_i.value} * 17'd205;
  assign tens      = {3'd0, prod_full[15:11]};
  assign prod      = 8'(tens * 8'd10);
  assign units     = item_i.value - prod;

  assign digit_pat = seg_lookup(item_i.value);
  assign tens_pat  = seg_lookup(tens);
  assign units_pat = seg_lookup(units);

  // Next row contents
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      rows_d[r] = rows_q[r];
      if (exec_i && item_i.row_sel == SelW'(r)) begin
        case (func)
          FUNC_DIGIT:   rows_d[r] = digit_pat;
          FUNC_DOT_ON:  rows_d[r] = rows_q[r] | DotMask;
          FUNC_DOT_OFF: rows_d[r] = rows_q[r] & ~DotMask;
          FUNC_CLEAR:   rows_d[r] = SegBlank;
          FUNC_DEC2:    rows_d[r] = tens_pat;
          default:      rows_d[r] = rows_q[r];
        endcase
      end else if (exec_i && func == FUNC_DEC2 && item_i.second_row == SelW'(r)) begin
        rows_d[r] = units_pat;
      end
    end
  end

  // Rotate the column on a refresh tick
  always_comb begin
    col_d = col_q;
    if (exec_i && func == FUNC_TICK) begin
      col_d = {col_q[SegW-2:0], col_q[SegW-1]};
    end
  end

  // Hold rows and column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= ColReset;
      for (int r = 0; r < NUM_ROWS; r++) begin
        rows_q[r] <= SegBlank;
      end
    end else begin
      col_q <= col_d;
      for (int r = 0; r < NUM_ROWS; r++) begin
        rows_q[r] <= rows_d[r];
      end
    end
  end

  // Active-low drive: a row pulls low when its bit for the column is lit
  for (genvar b = 0; b < DriveW; b++) begin : g_drive
    if (b < NUM_ROWS) begin : g_row
      assign result_o.row_drive[b] = ~|(rows_q[b] & col_q);
    end else begin : g_off
      assign result_o.row_drive[b] = 1'b1;
    end
  end
  assign result_o.column_drive = col_q;

`ifndef SYNTHESIS
  a_col_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(col_q))
    else $error("column pointer lost one-hot form");

  a_col_rotates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_i && func == FUNC_TICK) |=> (col_q == {$past(col_q[SegW-2:0]), $past(col_q[SegW-1])}))
    else $error("column did not advance after refresh tick");

  a_col_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(exec_i && func == FUNC_TICK) |=> $stable(col_q))
    else $error("column moved without a refresh tick");
`endif

endmodule

>>> rtl/led_matrix_scan_7seg.sv
`timescale 1ns / 1ps
// ============================================================================
// led_matrix_scan_7seg
// Multiplexed seven-segment / LED matrix scan driver with registered
// input and result stages.
// ============================================================================
// Usage: every transfer on the input channel carries one operation. A
// refresh tick returns one result (active-low row pattern and one-hot
// column) and steps the column from bit 0 to bit 7 and around; the other
// operations load, dot, clear or decimal-split into the segment rows and
// return nothing. An item waits in the input register and is applied at the
// edge that ends its stay there; a refresh result is captured at that edge
// into an output register and waits there until taken. One item is
// taken every cycle; a refresh tick holds in the input register only
// while a previous result is held and not taken in the same cycle.
module led_matrix_scan_7seg import lms7_pkg::*; #(
  parameter int unsigned NUM_ROWS = NumRowsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t result;
  logic      is_tick;
  logic      out_free;
  logic      exec;

  assign is_tick  = (func_e'(in_item_q.func) == FUNC_TICK);
  assign out_free = !out_valid_q || out_ready_i;
  assign exec     = in_valid_q && (!is_tick || out_free);
  assign in_ready_o = !in_valid_q || exec;

  // Hold the accepted item until it executes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  lms7_core #(
    .NUM_ROWS(NUM_ROWS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .exec_i  (exec),
    .item_i  (in_item_q),
    .result_o(result)
  );

  // Capture the refresh result; drop it after transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec && is_tick) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec && is_tick) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && is_tick) |-> out_free)
    else $error("refresh result overwrote an untaken result");

  a_stall_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && is_tick && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked refresh tick");

  a_out_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot(out_item_q.column_drive))
    else $error("result column is not one-hot");
`endif

endmodule

>>> test/tb_led_matrix_scan_7seg.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_led_matrix_scan_7seg
// Self-checking regression for the multiplexed seven-segment scan driver.
// ============================================================================
// Directed transfers load the glyph table extremes and every row operation,
// including ignored rows, blank indices, the two-digit split and the unused
// selectors. Random transfers then run in bursts and back to back. A local
// copy of the row store and column pointer predicts every scan result. Each
// scan transfer taken from the block is checked field by field, in order,
// while the result side stalls on its own pattern.
module tb_led_matrix_scan_7seg;
  import lms7_pkg::*;

  localparam int unsigned ROWS         = NumRowsDefault;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned DRAIN_CYCLES = 10;

  // Selectors with no operation behind them
  localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  // Glyphs 0-F, dot, minus; entry n sits at bits [8n +: 8]
  localparam logic [18*8-1:0] GLYPH_ROM = {
    8'h02, 8'h01, 8'h8E, 8'h9E, 8'h7A, 8'h9C, 8'h3E, 8'hEE, 8'hF6,
    8'hFE, 8'hE0, 8'hBE, 8'hB6, 8'h66, 8'hF2, 8'hDA, 8'h60, 8'hFC
  };

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  // Predicted segment store and column pointer
  logic [SegW-1:0] seg_rows [ROWS];
  logic [SegW-1:0] scan_col;
  out_item_t       pending_scans [$];
  out_item_t       scan_exp;

  int unsigned errors;
  int unsigned sent_cnt;
  int unsigned scans_sent;
  int unsigned scans_checked;
  int unsigned cycle_cnt;
  int unsigned burst_left;
  bit          bursty;

  led_matrix_scan_7seg #(
    .NUM_ROWS(ROWS)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d scans still pending", $time, cycle_cnt,
               pending_scans.size());
      $display("led_matrix_scan_7seg regression: fail");
      $finish;
    end
  end

  // Stall the result side in phases of varying pressure
  initial begin
    int unsigned ph_mode;
    int unsigned ph_left;
    ph_mode   = 0;
    ph_left   = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (ph_left == 0) begin
        ph_mode = $urandom_range(0, 3);
        ph_left = $urandom_range(16, 80);
      end
      ph_left = ph_left - 1;
      case (ph_mode)
        0: out_ready = 1'b1;
        1: out_ready = ($urandom_range(0, 1) != 0);
        2: out_ready = ($urandom_range(0, 7) == 0);
        default: out_ready = ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Check each result transfer against the oldest predicted scan
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_scans.size() == 0) begin
        errors = errors + 1;
        $display("%0t: unexpected result row_drive %h column_drive %h", $time,
                 out_item.row_drive, out_item.column_drive);
      end else begin
        scan_exp      = pending_scans.pop_front();
        scans_checked = scans_checked + 1;
        if (out_item.row_drive !== scan_exp.row_drive) begin
          errors = errors + 1;
          $display("%0t: row_drive mismatch: expected %h actual %h", $time,
                   scan_exp.row_drive, out_item.row_drive);
        end
        if (out_item.column_drive !== scan_exp.column_drive) begin
          errors = errors + 1;
          $display("%0t: column_drive mismatch: expected %h actual %h", $time,
                   scan_exp.column_drive, out_item.column_drive);
        end
      end
    end
  end

  function automatic logic [SegW-1:0] glyph(input logic [7:0] idx);
    if (idx < 18) return GLYPH_ROM[idx*8 +: 8];
    return '0;
  endfunction

  function automatic in_item_t make_op(input logic [2:0] fn, input logic [2:0] r1,
                                       input logic [2:0] r2, input logic [7:0] val);
    in_item_t it;
    it.func       = fn;
    it.row_sel    = r1;
    it.second_row = r2;
    it.value      = val;
    return it;
  endfunction

  // Apply one accepted transfer to the predicted store
  task automatic update_rows(input in_item_t it);
    logic [DriveW-1:0] lit;
    out_item_t         res;
    lit = '0;
    case (it.func)
      FUNC_TICK: begin
        for (int r = 0; r < DriveW; r++) begin
          if (r < ROWS && (seg_rows[r] & scan_col) != '0) lit[r] = 1'b1;
        end
        res.row_drive    = ~lit;
        res.column_drive = scan_col;
        pending_scans.push_back(res);
        scans_sent = scans_sent + 1;
        // Wrap after the last column or on a pointer that is not one-hot
        if (scan_col == 8'h80 || !$onehot(scan_col)) scan_col = ColReset;
        else scan_col = scan_col << 1;
      end
      FUNC_DIGIT: begin
        if (it.row_sel < ROWS) seg_rows[it.row_sel] = glyph(it.value);
      end
      FUNC_DOT_ON: begin
        if (it.row_sel < ROWS) seg_rows[it.row_sel] = seg_rows[it.row_sel] | DotMask;
      end
      FUNC_DOT_OFF: begin
        if (it.row_sel < ROWS) seg_rows[it.row_sel] = seg_rows[it.row_sel] & ~DotMask;
      end
      FUNC_CLEAR: begin
        if (it.row_sel < ROWS) seg_rows[it.row_sel] = SegBlank;
      end
      FUNC_DEC2: begin
        // Units first so that tens win when both name the same row
        if (it.second_row < ROWS) seg_rows[it.second_row] = glyph(8'(it.value % 10));
        if (it.row_sel < ROWS) seg_rows[it.row_sel] = glyph(8'(it.value / 10));
      end
      default: ;
    endcase
  endtask

  // Send one transfer; called at a falling edge and returns at one
  task automatic send_op(input in_item_t it);
    int unsigned gap;
    if (bursty && burst_left == 0) begin
      in_valid = 1'b0;
      gap      = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid = 1'b1;
    in_item  = it;
    do @(posedge clk); while (!in_ready);
    update_rows(it);
    sent_cnt = sent_cnt + 1;
    if (burst_left != 0) burst_left = burst_left - 1;
    @(negedge clk);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_op(make_op(FUNC_TICK, '0, '0, '0));
  endtask

  // Hold off input until every predicted scan has been taken
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_scans.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [2:0] pick_row();
    if ($urandom_range(0, 9) < 8) return 3'($urandom_range(0, ROWS - 1));
    return 3'($urandom_range(ROWS, 7));
  endfunction

  function automatic in_item_t random_op();
    int unsigned roll;
    in_item_t    it;
    roll = $urandom_range(0, 99);
    it   = make_op(FUNC_TICK, pick_row(), pick_row(), 8'($urandom_range(0, 255)));
    if (roll < 40) it.func = FUNC_TICK;
    else if (roll < 55) begin
      it.func = FUNC_DIGIT;
      if ($urandom_range(0, 3) != 0) it.value = 8'($urandom_range(0, 17));
    end
    else if (roll < 63) it.func = FUNC_DOT_ON;
    else if (roll < 71) it.func = FUNC_DOT_OFF;
    else if (roll < 78) it.func = FUNC_CLEAR;
    else if (roll < 95) it.func = FUNC_DEC2;
    else if (roll < 97) it.func = FUNC_SPARE_LO;
    else it.func = FUNC_SPARE_HI;
    return it;
  endfunction

  // Glyph table ends, blank indices and an ignored row, then a full sweep
  task automatic test_table_extremes();
    send_op(make_op(FUNC_DIGIT, 3'd0, 3'd0, 8'd0));
    send_op(make_op(FUNC_DIGIT, 3'd1, 3'd0, 8'd17));
    send_op(make_op(FUNC_DIGIT, 3'd2, 3'd0, 8'd16));
    send_op(make_op(FUNC_DIGIT, 3'd3, 3'd7, 8'd255));
    send_op(make_op(FUNC_DIGIT, 3'd4, 3'd0, 8'd18));
    send_op(make_op(FUNC_DIGIT, 3'd7, 3'd0, 8'd8));
    send_ticks(8);
  endtask

  // Dot, clear, decimal split corners and unused selectors
  task automatic test_row_ops();
    send_op(make_op(FUNC_DOT_ON, 3'd3, 3'd0, 8'd0));
    send_op(make_op(FUNC_DOT_OFF, 3'd0, 3'd0, 8'd0));
    send_op(make_op(FUNC_CLEAR, 3'd1, 3'd0, 8'd0));
    send_op(make_op(FUNC_DEC2, 3'd2, 3'd4, 8'd255));
    send_op(make_op(FUNC_DEC2, 3'd5, 3'd0, 8'd47));
    send_op(make_op(FUNC_DEC2, 3'd1, 3'd1, 8'd99));
    send_op(make_op(FUNC_DEC2, 3'd3, 3'd6, 8'd180));
    send_op(make_op(FUNC_SPARE_LO, 3'd2, 3'd2, 8'd255));
    send_op(make_op(FUNC_SPARE_HI, 3'd4, 3'd1, 8'd1));
    send_op(make_op(FUNC_DOT_ON, 3'd6, 3'd0, 8'd0));
    send_ticks(8);
  endtask

  task automatic test_random_scan(input int unsigned n);
    repeat (n) send_op(random_op());
  endtask

  // Full-rate input with no sender gaps
  task automatic test_back_to_back(input int unsigned n);
    bursty = 1'b0;
    test_random_scan(n);
    bursty = 1'b1;
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_item       = '0;
    errors        = 0;
    sent_cnt      = 0;
    scans_sent    = 0;
    scans_checked = 0;
    cycle_cnt     = 0;
    burst_left    = 0;
    bursty        = 1'b1;
    for (int r = 0; r < ROWS; r++) seg_rows[r] = '0;
    scan_col = ColReset;

    // Reset
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_table_extremes();
    test_row_ops();
    test_random_scan(200);
    wait_drained();
    test_back_to_back(100);
    test_random_scan(150);
    wait_drained();

    $display("Sent %0d transfers with %0d scans; %0d scan results checked.", sent_cnt,
             scans_sent, scans_checked);
    $display("Covered glyph extremes, dots, clears, decimal splits and idle selectors.");
    if (errors == 0 && pending_scans.size() == 0) begin
      $display("led_matrix_scan_7seg regression: pass");
    end else begin
      $display("led_matrix_scan_7seg regression: fail");
    end
    $finish;
  end

endmodule
